/* rtl/first_fit_page_run_allocator_assert.svh */
// Assertion helpers for the page run allocator.
`ifndef FIRST_FIT_PAGE_RUN_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PAGE_RUN_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FFPR_ASSERT_IMPLY(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("ffpr: same-cycle check failed");

// Next-cycle implication.
`define FFPR_ASSERT_NEXT(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("ffpr: next-cycle check failed");

`endif

/* rtl/ffpr_pkg.sv */
`default_nettype none
package ffpr_pkg;

   localparam int DEF_NUM_PAGES   = 4096;
   localparam int WORD_W          = 64;
   localparam int COUNT_FIELD_MAX = 8191;

   localparam int MODE_W   = 2;
   localparam int START_W  = 12;
   localparam int COUNT_W  = 13;
   localparam int STATUS_W = 2;
   localparam int DATA_W   = 32;

   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MAP   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNMAP = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

endpackage
`default_nettype wire

/* rtl/ffpr_ram.sv */
`default_nettype none
module ffpr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* rtl/first_fit_page_run_allocator.sv */
// First-fit page run allocator.
// req channel: one beat per request (mode, start_page, page_count); req_tready
// is high only while the block is idle, so one request is in work at a time.
// rsp channel: one beat per request (status, run_start, pages_in_use).
// The in-use map sits in a RAM of 64-bit words, W = ceil(NUM_PAGES/64) deep.
// Bad requests go straight to the result. Free, map and unmap read, modify and
// write back each map word of the run. An allocate first scans for a free run:
// a fully free or fully used word is judged as a whole and a mixed word page by
// page, after which the scan reads the next word anew; a run that is found is
// marked like a map. If no run is found, the scan ends with no space.
// The block is back in idle, ready for a new request, as the result is loaded.
// After reset the block sweeps zeros through the map RAM, one word per cycle;
// req_tready stays low until the sweep ends.
// Results sit in an output register; while the receiver stalls the block
// takes and works the next request, then waits with its result until the
// register is free.
`default_nettype none
module first_fit_page_run_allocator import ffpr_pkg::*; #(
   parameter int NUM_PAGES = DEF_NUM_PAGES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // [1:0] mode, [13:2] start_page, [26:14] page_count
   input  wire logic [DATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // [1:0] status, [13:2] run_start, [26:14] pages_in_use
   output logic      [DATA_W-1:0] rsp_tdata
);
   localparam int PW  = $clog2(NUM_PAGES);
   localparam int XW  = (PW + 2 > COUNT_W + 2) ? PW + 2 : COUNT_W + 2;
   localparam int NW  = (NUM_PAGES + WORD_W - 1) / WORD_W;
   localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
   localparam int BW  = $clog2(WORD_W);
   localparam int TAIL = NUM_PAGES % WORD_W;
   localparam logic [WORD_W-1:0] TAIL_MASK =
      (TAIL == 0) ? {WORD_W{1'b1}} : ({WORD_W{1'b1}} >> (WORD_W - TAIL));
   localparam logic [COUNT_W-1:0] COUNT_MAX =
      COUNT_W'((NUM_PAGES < COUNT_FIELD_MAX) ? NUM_PAGES : COUNT_FIELD_MAX);
   localparam logic [WAW-1:0] LAST_WORD = WAW'(NW - 1);
   localparam logic [XW-1:0]  NP_X      = XW'(NUM_PAGES);

   localparam logic [3:0] S_CLEAR      = 4'd0;
   localparam logic [3:0] S_IDLE       = 4'd1;
   localparam logic [3:0] S_SCAN_RD    = 4'd2;
   localparam logic [3:0] S_SCAN_EVAL  = 4'd3;
   localparam logic [3:0] S_SCAN_BIT   = 4'd4;
   localparam logic [3:0] S_MARK_SETUP = 4'd5;
   localparam logic [3:0] S_MARK_RD    = 4'd6;
   localparam logic [3:0] S_MARK_WR    = 4'd7;
   localparam logic [3:0] S_FINISH     = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [COUNT_W-1:0]  len_ff, len_in;
   logic [PW-1:0]       first_ff, first_in;
   logic [PW-1:0]       last_ff, last_in;
   logic [WAW-1:0]      word_ff, word_in;
   logic [BW-1:0]       bit_ff, bit_in;
   logic [WORD_W-1:0]   free_ff, free_in;
   logic [XW-1:0]       run_ff, run_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [WAW-1:0]    wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [WAW-1:0]    rd_addr;
   logic [WORD_W-1:0] rd_data;

   ffpr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NW)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   logic [MODE_W-1:0]  req_mode;
   logic [START_W-1:0] req_start;
   logic [COUNT_W-1:0] req_count;
   logic               req_bad;
   logic [WORD_W-1:0]  word_free;
   logic [XW-1:0]      word_base;
   logic [XW-1:0]      bit_pos;
   logic               is_first_word;
   logic               is_last_word;
   logic [BW-1:0]      lo_off;
   logic [BW-1:0]      hi_off;
   logic [WORD_W-1:0]  run_mask;
   logic               set_marks;
   logic               rsp_free;
   logic [XW-1:0]      count_sum;
   logic [COUNT_W-1:0] count_next;

   assign req_mode  = req_tdata[1:0];
   assign req_start = req_tdata[13:2];
   assign req_count = req_tdata[26:14];
   assign req_bad   = (req_count == '0) ||
                      ((req_mode == MODE_ALLOC) ? (XW'(req_count) > NP_X)
                                                : (XW'(req_start) + XW'(req_count) > NP_X));

   assign word_free = ~rd_data & ((word_ff == LAST_WORD) ? TAIL_MASK : {WORD_W{1'b1}});
   assign word_base = XW'(word_ff) << BW;
   assign bit_pos   = word_base | XW'(bit_ff);

   assign is_first_word = (XW'(word_ff) == (XW'(first_ff) >> BW));
   assign is_last_word  = (XW'(word_ff) == (XW'(last_ff) >> BW));
   assign lo_off   = is_first_word ? first_ff[BW-1:0] : '0;
   assign hi_off   = is_last_word ? last_ff[BW-1:0] : {BW{1'b1}};
   assign run_mask = ({WORD_W{1'b1}} << lo_off) & ({WORD_W{1'b1}} >> (~hi_off));
   assign set_marks = (mode_ff == MODE_ALLOC) || (mode_ff == MODE_MAP);

   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign count_sum = XW'(count_ff) + XW'(len_ff);

   always_comb begin
      count_next = count_ff;
      if (status_ff == ST_OK) begin
         if (mode_ff == MODE_ALLOC) begin
            count_next = (count_sum > XW'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(count_sum);
         end else if (mode_ff == MODE_FREE) begin
            count_next = (count_ff > len_ff) ? count_ff - len_ff : '0;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      len_in       = len_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      word_in      = word_ff;
      bit_in       = bit_ff;
      free_in      = free_ff;
      run_in       = run_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = word_ff;
      wr_data      = '0;
      rd_addr      = word_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (word_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end else begin
               word_in = word_ff + 1'b1;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               mode_in   = req_mode;
               len_in    = req_count;
               first_in  = PW'(req_start);
               run_in    = '0;
               word_in   = '0;
               status_in = ST_OK;
               if (req_bad) begin
                  status_in = ST_BAD;
                  state_in  = S_FINISH;
               end else if (req_mode == MODE_ALLOC) begin
                  state_in = S_SCAN_RD;
               end else begin
                  state_in = S_MARK_SETUP;
               end
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_EVAL;
         end
         S_SCAN_EVAL: begin
            rd_addr = word_ff + 1'b1;
            if (word_free == {WORD_W{1'b1}} &&
                run_ff + XW'(WORD_W) >= XW'(len_ff)) begin
               first_in = PW'(word_base - run_ff);
               state_in = S_MARK_SETUP;
            end else if (word_free != '0 && word_free != {WORD_W{1'b1}}) begin
               free_in  = word_free;
               bit_in   = '0;
               state_in = S_SCAN_BIT;
            end else begin
               run_in = (word_free == '0) ? '0 : run_ff + XW'(WORD_W);
               if (word_ff == LAST_WORD) begin
                  status_in = ST_NOSPACE;
                  state_in  = S_FINISH;
               end else begin
                  word_in = word_ff + 1'b1;
               end
            end
         end
         S_SCAN_BIT: begin
            bit_in = bit_ff + 1'b1;
            if (free_ff[bit_ff] && run_ff + 1'b1 >= XW'(len_ff)) begin
               first_in = PW'(bit_pos - run_ff);
               state_in = S_MARK_SETUP;
            end else begin
               run_in = free_ff[bit_ff] ? run_ff + 1'b1 : '0;
               if (bit_ff == {BW{1'b1}}) begin
                  if (word_ff == LAST_WORD) begin
                     status_in = ST_NOSPACE;
                     state_in  = S_FINISH;
                  end else begin
                     word_in  = word_ff + 1'b1;
                     state_in = S_SCAN_RD;
                  end
               end
            end
         end
         S_MARK_SETUP: begin
            last_in  = PW'(XW'(first_ff) + XW'(len_ff) - 1'b1);
            word_in  = WAW'(XW'(first_ff) >> BW);
            state_in = S_MARK_RD;
         end
         S_MARK_RD: begin
            state_in = S_MARK_WR;
         end
         S_MARK_WR: begin
            wr_en   = 1'b1;
            wr_data = set_marks ? (rd_data | run_mask) : (rd_data & ~run_mask);
            if (is_last_word) begin
               state_in = S_FINISH;
            end else begin
               word_in  = word_ff + 1'b1;
               state_in = S_MARK_RD;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               count_in     = count_next;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[1:0]   = status_ff;
               rsp_data_in[13:2]  = (status_ff == ST_OK && mode_ff == MODE_ALLOC) ?
                                    START_W'(first_ff) : '0;
               rsp_data_in[26:14] = count_next;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         word_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      len_ff      <= len_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      bit_ff      <= bit_in;
      free_ff     <= free_in;
      run_ff      <= run_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`include "first_fit_page_run_allocator_assert.svh"

   `FFPR_ASSERT_IMPLY(a_count_cap, clock, reset, 1'b1, count_ff <= COUNT_MAX)
   `FFPR_ASSERT_IMPLY(a_scan_short, clock, reset, state_ff == S_SCAN_BIT,
      run_ff < XW'(len_ff))
   `FFPR_ASSERT_IMPLY(a_nospace_zero, clock, reset,
      rsp_tvalid && rsp_tdata[1:0] != ST_OK, rsp_tdata[13:2] == '0)
   `FFPR_ASSERT_NEXT(a_finish_out, clock, reset, state_ff == S_FINISH && rsp_free,
      rsp_valid_ff && state_ff == S_IDLE)

endmodule
`default_nettype wire

/* verif/page_allocation_checker.sv */
`timescale 1ns / 1ps
module page_allocation_checker import ffpr_pkg::*; #(
   parameter int NUM_PAGES = DEF_NUM_PAGES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic              req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,
   input  wire logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire logic [DATA_W-1:0] rsp_tdata,
   output int                     mismatches,
   output int                     grants_pending
);

   localparam int COUNT_MAX = (NUM_PAGES < COUNT_FIELD_MAX) ? NUM_PAGES : COUNT_FIELD_MAX;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [START_W-1:0]  run_start;
      logic [COUNT_W-1:0]  pages_in_use;
   } grant_type;

   bit [NUM_PAGES-1:0] page_busy;
   int unsigned        pages_held;
   grant_type          grant_q[$];

   task automatic apply_page_request(input logic [MODE_W-1:0] mode, input int unsigned first,
                                     input int unsigned len, output grant_type grant);
      int unsigned run_len;
      int unsigned run_head;
      int unsigned p;
      bit          found;
      grant    = '0;
      found    = 1'b0;
      run_len  = 0;
      run_head = 0;
      grant.status = ST_OK;
      if (mode == MODE_ALLOC) begin
         if (len == 0 || len > NUM_PAGES) begin
            grant.status = ST_BAD;
         end else begin
            for (p = 0; p < NUM_PAGES && !found; p++) begin
               if (page_busy[p]) begin
                  run_len = 0;
               end else begin
                  if (run_len == 0) run_head = p;
                  run_len++;
                  if (run_len >= len) found = 1'b1;
               end
            end
            if (!found) begin
               grant.status = ST_NOSPACE;
            end else begin
               for (p = run_head; p < run_head + len; p++) page_busy[p] = 1'b1;
               pages_held = (pages_held + len > COUNT_MAX) ? COUNT_MAX : pages_held + len;
               grant.run_start = run_head[START_W-1:0];
            end
         end
      end else if (len == 0 || first + len > NUM_PAGES) begin
         grant.status = ST_BAD;
      end else begin
         for (p = first; p < first + len; p++) page_busy[p] = (mode == MODE_MAP);
         if (mode == MODE_FREE) pages_held = (pages_held > len) ? pages_held - len : 0;
      end
      grant.pages_in_use = pages_held[COUNT_W-1:0];
   endtask

   always @(posedge clock) begin
      grant_type want;
      grant_type seen;
      if (reset) begin
         page_busy  = '0;
         pages_held = 0;
         mismatches = 0;
         grant_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.status       = rsp_tdata[STATUS_W-1:0];
            seen.run_start    = rsp_tdata[STATUS_W +: START_W];
            seen.pages_in_use = rsp_tdata[STATUS_W+START_W +: COUNT_W];
            if (grant_q.size() == 0) begin
               $display("%0t: unexpected rsp beat %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = grant_q.pop_front();
               if (seen.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, seen.status);
                  mismatches++;
               end
               if (seen.run_start !== want.run_start) begin
                  $display("%0t: run_start expected %0d actual %0d", $time,
                           want.run_start, seen.run_start);
                  mismatches++;
               end
               if (seen.pages_in_use !== want.pages_in_use) begin
                  $display("%0t: pages_in_use expected %0d actual %0d", $time,
                           want.pages_in_use, seen.pages_in_use);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_page_request(req_tdata[MODE_W-1:0], 32'(req_tdata[MODE_W +: START_W]),
                               32'(req_tdata[MODE_W+START_W +: COUNT_W]), want);
            grant_q.push_back(want);
         end
      end
      grants_pending = grant_q.size();
   end

endmodule

/* verif/first_fit_page_run_allocator_test.sv */
`timescale 1ns / 1ps
module first_fit_page_run_allocator_test import ffpr_pkg::*;;

   localparam int PAGES       = DEF_NUM_PAGES;
   localparam int RANDOM_REQS = 800;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_WAIT  = 100;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   // [1:0] mode, [13:2] start_page, [26:14] page_count
   logic [DATA_W-1:0] req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   // [1:0] status, [13:2] run_start, [26:14] pages_in_use
   logic [DATA_W-1:0] rsp_tdata;

   int mismatches;
   int grants_pending;
   int req_idle_pct = 13;
   int rsp_idle_pct = 57;
   int quiet_cycles = 0;

   first_fit_page_run_allocator #(.NUM_PAGES(PAGES)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   page_allocation_checker #(.NUM_PAGES(PAGES)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatches     (mismatches),
      .grants_pending (grants_pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // returns at the edge where the beat was taken
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [START_W-1:0] first,
                               input logic [COUNT_W-1:0] len);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'({len, first, mode});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic random_request();
      int unsigned       roll;
      int unsigned       first;
      int unsigned       len;
      logic [MODE_W-1:0] mode;
      roll = $urandom_range(99);
      mode = MODE_W'($urandom_range(3));
      if (roll < 8) begin
         // random mode, often malformed: zero length, wild length, or run past the end
         first = $urandom_range(PAGES - 1);
         case ($urandom_range(2))
            0: len = 0;
            1: len = $urandom_range(COUNT_FIELD_MAX);
            default: len = PAGES - first + 1 + $urandom_range(63);
         endcase
      end else if (roll < 50) begin
         mode  = MODE_ALLOC;
         first = $urandom_range(PAGES - 1);
         len   = ($urandom_range(15) == 0) ? $urandom_range(512, 1) : $urandom_range(32, 1);
      end else begin
         mode  = (roll < 75) ? MODE_FREE : (roll < 88) ? MODE_MAP : MODE_UNMAP;
         first = ($urandom_range(3) == 0) ? $urandom_range(PAGES - 1) : $urandom_range(1023);
         len   = $urandom_range(64, 1);
         if (first + len > PAGES) len = PAGES - first;
      end
      send_request(mode, first[START_W-1:0], len[COUNT_W-1:0]);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bad requests
      send_request(MODE_ALLOC, 0, 0);
      send_request(MODE_FREE, 5, 0);
      send_request(MODE_MAP, 4095, 2);
      send_request(MODE_UNMAP, 1, 4096);
      send_request(MODE_ALLOC, 0, 4097);
      send_request(MODE_ALLOC, 4095, 8191);
      // whole map, no space, count saturation
      send_request(MODE_ALLOC, 0, 4096);
      send_request(MODE_ALLOC, 0, 1);
      send_request(MODE_UNMAP, 0, 4096);
      send_request(MODE_ALLOC, 0, 10);
      send_request(MODE_FREE, 0, 4096);
      send_request(MODE_FREE, 4000, 96);
      // last page, fragmented holes
      send_request(MODE_MAP, 0, 4095);
      send_request(MODE_ALLOC, 0, 1);
      send_request(MODE_ALLOC, 0, 1);
      send_request(MODE_UNMAP, 100, 3);
      send_request(MODE_MAP, 101, 1);
      send_request(MODE_ALLOC, 0, 2);
      send_request(MODE_ALLOC, 0, 1);
      send_request(MODE_FREE, 0, 4096);
      send_request(MODE_MAP, 4095, 1);
      send_request(MODE_ALLOC, 0, 4096);
      send_request(MODE_UNMAP, 4095, 1);
      send_request(MODE_ALLOC, 2048, 4096);
      send_request(MODE_FREE, 0, 4096);

      for (int i = 0; i < RANDOM_REQS; i++) begin
         if (i == RANDOM_REQS / 3) begin
            req_idle_pct = 57;
            rsp_idle_pct = 13;
         end else if (i == 2 * RANDOM_REQS / 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         // keep the map from clogging up with fragments
         if (i % 64 == 63) send_request(MODE_FREE, 0, 4096);
         else random_request();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (grants_pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* first_fit_page_run_allocator.f */
+incdir+rtl
rtl/ffpr_pkg.sv
rtl/ffpr_ram.sv
rtl/first_fit_page_run_allocator.sv
verif/page_allocation_checker.sv
verif/first_fit_page_run_allocator_test.sv
